// ----- design/cwt_pkg.sv -----
// Shared types, codes and helper functions for the caller whitelist table.
`timescale 1ns / 1ps
`default_nettype none

package cwt_pkg;

    // Widths of one table word and of the command and result fields
    localparam int DIGITS_W = 64;
    localparam int ELEN_W   = 4;
    localparam int ENT_W    = DIGITS_W + ELEN_W;
    localparam int NLEN_W   = 5;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 3;
    localparam int IDX_IN_W = 6;
    localparam int CNT_O_W  = 7;

    // Command codes
    localparam logic [OP_W-1:0] OP_CHECK  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd5;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd6;

    // Length limits of a number
    localparam logic [NLEN_W-1:0] LEN_OVER      = 5'd16;
    localparam logic [NLEN_W-1:0] MIN_VALID_LEN = 5'd10;
    localparam logic [3:0]        DIGIT_LIMIT   = 4'd10;

    typedef logic [DIGITS_W-1:0] t_digits;

    // Keep the nibbles below len, zero the rest
    function automatic t_digits len_mask(input logic [NLEN_W-1:0] len);
        t_digits m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (NLEN_W'(i) < len) begin
                m[4*i +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

    // True when every character below len is a digit
    function automatic logic all_digits(input t_digits d, input logic [NLEN_W-1:0] len);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if ((NLEN_W'(i) < len) && (d[4*i +: 4] >= DIGIT_LIMIT)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- design/cwt_if.sv -----
// Valid/ready channel interfaces for commands and responses.
`timescale 1ns / 1ps
`default_nettype none

interface cwt_cmd_if;
    import cwt_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [DIGITS_W-1:0] number_digits;
    logic [NLEN_W-1:0]   number_length;
    logic [IDX_IN_W-1:0] entry_index;

    modport source (output valid, operation, number_digits, number_length, entry_index,
                    input ready);
    modport sink   (input valid, operation, number_digits, number_length, entry_index,
                    output ready);
endinterface

interface cwt_rsp_if;
    import cwt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic                authorized;
    logic [DIGITS_W-1:0] entry_digits;
    logic [ELEN_W-1:0]   entry_length;
    logic [CNT_O_W-1:0]  entry_count;
    logic                persist_request;

    modport source (output valid, status, authorized, entry_digits, entry_length,
                    entry_count, persist_request, input ready);
    modport sink   (input valid, status, authorized, entry_digits, entry_length,
                    entry_count, persist_request, output ready);
endinterface

`default_nettype wire

// ----- design/cwt_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module cwt_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word; the read word is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/caller_whitelist_table_core.sv -----
// Ordered phone number whitelist table with search, compaction and a sequencer.
// Sequencing: clear, append and rejected commands go from decode straight to done;
//   a read adds a RAM wait state; check, add and remove read and compare each stored
//   entry in turn, and a remove then moves each later entry down by a read and a write.
// Throughput: one command at a time; the next is accepted once the sequencer is idle,
//   while the previous result may still wait in the output register.
// Reset clears the entry count, sequencer and output valid; table RAM needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module caller_whitelist_table_core
    import cwt_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int MAX_DIGITS = 15
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cwt_cmd_if.sink    i_cmd,
    cwt_rsp_if.source  o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0]  ENTRIES_C = CNT_W'(ENTRIES);
    localparam logic [NLEN_W-1:0] MAX_LEN_C = NLEN_W'(MAX_DIGITS);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SRCH_RD  = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_SHF_RD   = 3'd4;
    localparam logic [2:0] S_SHF_WR   = 3'd5;
    localparam logic [2:0] S_RD_WAIT  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op;
    t_digits             r_digits;
    logic [NLEN_W-1:0]   r_len;
    logic [IDX_IN_W-1:0] r_idx;
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0]    r_count, n_count;

    // Result being built
    logic [STAT_W-1:0]   r_status, n_status;
    logic                r_auth, n_auth;
    t_digits             r_rd_digits, n_rd_digits;
    logic [ELEN_W-1:0]   r_rd_len, n_rd_len;
    logic                r_persist, n_persist;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_o_status;
    logic                r_o_auth;
    t_digits             r_o_digits;
    logic [ELEN_W-1:0]   r_o_len;
    logic [CNT_O_W-1:0]  r_o_count;
    logic                r_o_persist;
    logic                out_load;

    // Table RAM ports
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    logic                cmd_fire;
    logic [NLEN_W-1:0]   in_len;
    logic                num_valid;
    logic                hit;
    logic                full;
    logic [CNT_W-1:0]    ptr_inc;
    logic [ELEN_W-1:0]   st_len;
    t_digits             st_digits;

    assign cmd_fire = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // Clamp an overlong length to the "too long" code
    assign in_len = (i_cmd.number_length > LEN_OVER) ? LEN_OVER : i_cmd.number_length;

    // Shared word checks
    assign num_valid = (r_len >= MIN_VALID_LEN) && (r_len <= MAX_LEN_C)
                       && all_digits(r_digits, r_len);
    assign hit = !r_len[NLEN_W-1] && (ram_rdata[ENT_W-1 -: ELEN_W] == r_len[ELEN_W-1:0])
                 && (ram_rdata[DIGITS_W-1:0] == r_digits);
    assign full    = (r_count == ENTRIES_C);
    assign ptr_inc = r_ptr + CNT_W'(1);

    // Truncated form for a word written by append or add
    assign st_len    = (r_len > MAX_LEN_C) ? MAX_LEN_C[ELEN_W-1:0] : r_len[ELEN_W-1:0];
    assign st_digits = r_digits & len_mask({1'b0, st_len});

    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    cwt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequence one command
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_status    = r_status;
        n_auth      = r_auth;
        n_rd_digits = r_rd_digits;
        n_rd_len    = r_rd_len;
        n_persist   = r_persist;
        ram_we      = 1'b0;
        ram_waddr   = r_count[IDX_W-1:0];
        ram_wdata   = {st_len, st_digits};
        ram_raddr   = r_ptr[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                n_status    = ST_OK;
                n_auth      = 1'b0;
                n_rd_digits = '0;
                n_rd_len    = '0;
                n_persist   = 1'b0;
                n_ptr       = '0;
                if (cmd_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (r_op) inside
                    OP_CHECK: begin
                        if (r_len != '0 && !r_len[NLEN_W-1]) begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    OP_ADD, OP_REMOVE: begin
                        if (!num_valid) begin
                            n_status = ST_INVALID;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    OP_READ: begin
                        if ({1'b0, r_idx} >= CNT_O_W'(r_count)) begin
                            n_status = ST_RANGE;
                        end else begin
                            ram_raddr = r_idx[IDX_W-1:0];
                            n_state   = S_RD_WAIT;
                        end
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    OP_APPEND: begin
                        if (full || r_len == '0) begin
                            n_status = ST_IGNORED;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    default: begin
                        n_status = ST_IGNORED;
                    end
                endcase
            end
            S_SRCH_RD: begin
                if (r_ptr >= r_count) begin
                    // End of table without a match
                    n_state = S_DONE;
                    if (r_op == OP_REMOVE) begin
                        n_status = ST_NOT_FOUND;
                    end else if (r_op == OP_ADD) begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            n_count   = r_count + CNT_W'(1);
                            n_persist = 1'b1;
                        end
                    end
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (hit) begin
                    n_state = S_DONE;
                    if (r_op == OP_CHECK) begin
                        n_auth = 1'b1;
                    end else if (r_op == OP_ADD) begin
                        n_status = ST_PRESENT;
                    end else begin
                        n_state = S_SHF_RD;
                    end
                end else begin
                    n_ptr   = ptr_inc;
                    n_state = S_SRCH_RD;
                end
            end
            S_SHF_RD: begin
                if (ptr_inc >= r_count) begin
                    n_count   = r_count - CNT_W'(1);
                    n_persist = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    ram_raddr = ptr_inc[IDX_W-1:0];
                    n_state   = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                // Move the next entry down one place
                ram_we    = 1'b1;
                ram_waddr = r_ptr[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_ptr     = ptr_inc;
                n_state   = S_SHF_RD;
            end
            S_RD_WAIT: begin
                n_rd_digits = ram_rdata[DIGITS_W-1:0];
                n_rd_len    = ram_rdata[ENT_W-1 -: ELEN_W];
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold or drop the output word
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Command capture and working registers
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_op     <= i_cmd.operation;
            r_digits <= i_cmd.number_digits & len_mask(in_len);
            r_len    <= in_len;
            r_idx    <= i_cmd.entry_index;
        end
        r_ptr       <= n_ptr;
        r_status    <= n_status;
        r_auth      <= n_auth;
        r_rd_digits <= n_rd_digits;
        r_rd_len    <= n_rd_len;
        r_persist   <= n_persist;
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status  <= r_status;
            r_o_auth    <= r_auth;
            r_o_digits  <= r_rd_digits;
            r_o_len     <= r_rd_len;
            r_o_count   <= CNT_O_W'(r_count);
            r_o_persist <= r_persist;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.authorized      = r_o_auth;
    assign o_rsp.entry_digits    = r_o_digits;
    assign o_rsp.entry_length    = r_o_len;
    assign o_rsp.entry_count     = r_o_count;
    assign o_rsp.persist_request = r_o_persist;

    // Entry count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ENTRIES_C)
        else $error("entry count above table size");

    // A save is requested only with a good status
    a_persist_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.persist_request) |-> (o_rsp.status == ST_OK))
        else $error("persist request with error status");

    // A match needs a non-empty table
    a_auth_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.authorized) |->
            (o_rsp.status == ST_OK && o_rsp.entry_count != '0))
        else $error("authorized with empty table");

    // Compaction moves only entries inside the table
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHF_WR) |-> (ptr_inc < r_count))
        else $error("compaction beyond last entry");

    // A finished remove shrinks the table by one
    a_remove_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHF_RD && ptr_inc >= r_count) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not shrink table");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the caller whitelist table core.
`timescale 1ns / 1ps

module tb_top;
    import cwt_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int MAX_CHARS      = 15;
    localparam int POOL_SIZE      = 24;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int PRESSURE_AT    = 400;
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 40;
    localparam int WATCHDOG_LIMIT = 3000;

    // Operation codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [DIGITS_W-1:0] digits;
        logic [NLEN_W-1:0]   len;
        logic [IDX_IN_W-1:0] idx;
    } cmd_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic                authorized;
        logic [DIGITS_W-1:0] entry_digits;
        logic [ELEN_W-1:0]   entry_length;
        logic [CNT_O_W-1:0]  entry_count;
        logic                persist_request;
    } rsp_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cwt_cmd_if cmd_ch ();
    cwt_rsp_if rsp_ch ();

    caller_whitelist_table_core #(
        .ENTRIES    (TABLE_DEPTH),
        .MAX_DIGITS (MAX_CHARS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the whitelist
    logic [DIGITS_W-1:0] wl_digits [TABLE_DEPTH];
    logic [ELEN_W-1:0]   wl_len    [TABLE_DEPTH];
    int                  wl_count = 0;

    cmd_word_t pending_cmds [$];
    rsp_word_t predicted_rsp [$];

    logic [DIGITS_W-1:0] pool_digits [POOL_SIZE];
    logic [NLEN_W-1:0]   pool_len    [POOL_SIZE];

    int   mismatch_count = 0;
    int   accepted_cmds  = 0;
    int   idle_cycles    = 0;
    int   send_gap       = 0;
    int   stall_left     = 0;
    bit   send_calm      = 1'b0;
    bit   recv_calm      = 1'b0;
    bit   pressure_done  = 1'b0;
    logic cmd_taken      = 1'b0;

    // Nibbles below len set, the rest clear
    function automatic logic [DIGITS_W-1:0] char_mask(input logic [NLEN_W-1:0] len);
        if (len >= LEN_OVER) begin
            return '1;
        end
        return (64'd1 << (4 * int'(len))) - 64'd1;
    endfunction

    function automatic bit is_valid_number(input logic [DIGITS_W-1:0] d,
                                           input logic [NLEN_W-1:0] len);
        if (len < MIN_VALID_LEN || int'(len) > MAX_CHARS) begin
            return 1'b0;
        end
        for (int i = 0; i < int'(len); i++) begin
            if (d[4*i +: 4] >= DIGIT_LIMIT) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Position of the first exact match, -1 when absent
    function automatic int find_number(input logic [DIGITS_W-1:0] d,
                                       input logic [NLEN_W-1:0] len);
        if (len >= LEN_OVER) begin
            return -1;
        end
        for (int i = 0; i < wl_count; i++) begin
            if (wl_len[i] == len[ELEN_W-1:0] && wl_digits[i] == d) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Truncate to the longest entry and place at the end
    function automatic void append_number(input logic [DIGITS_W-1:0] d,
                                          input logic [NLEN_W-1:0] len);
        logic [NLEN_W-1:0] n;
        n = (int'(len) > MAX_CHARS) ? NLEN_W'(MAX_CHARS) : len;
        wl_digits[wl_count] = d & char_mask(n);
        wl_len[wl_count]    = n[ELEN_W-1:0];
        wl_count++;
    endfunction

    // Apply one command to the shadow table and build its result word
    function automatic rsp_word_t whitelist_predict(input cmd_word_t c);
        rsp_word_t         r;
        logic [NLEN_W-1:0] n;
        logic [DIGITS_W-1:0] d;
        int                hit;
        r   = '0;
        n   = (c.len > LEN_OVER) ? LEN_OVER : c.len;
        d   = c.digits & char_mask(n);
        hit = find_number(d, n);
        case (c.op)
            OP_CHECK: begin
                r.authorized = (n != '0) && (hit >= 0);
            end
            OP_ADD: begin
                if (!is_valid_number(d, n)) begin
                    r.status = ST_INVALID;
                end else if (hit >= 0) begin
                    r.status = ST_PRESENT;
                end else if (wl_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    append_number(d, n);
                    r.persist_request = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!is_valid_number(d, n)) begin
                    r.status = ST_INVALID;
                end else if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    // Close the gap, keep the order
                    for (int i = hit; i < wl_count - 1; i++) begin
                        wl_digits[i] = wl_digits[i+1];
                        wl_len[i]    = wl_len[i+1];
                    end
                    wl_count--;
                    r.persist_request = 1'b1;
                end
            end
            OP_READ: begin
                if (int'(c.idx) >= wl_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.entry_digits = wl_digits[c.idx];
                    r.entry_length = wl_len[c.idx];
                end
            end
            OP_CLEAR: begin
                wl_count = 0;
            end
            OP_APPEND: begin
                if (wl_count >= TABLE_DEPTH || n == '0) begin
                    r.status = ST_IGNORED;
                end else begin
                    append_number(d, n);
                end
            end
            default: begin
                r.status = ST_IGNORED;
            end
        endcase
        r.entry_count = CNT_O_W'(wl_count);
        return r;
    endfunction

    function automatic logic [DIGITS_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [DIGITS_W-1:0] d,
                            input int len, input int idx);
        cmd_word_t c;
        c.op     = op;
        c.digits = d;
        c.len    = NLEN_W'(len);
        c.idx    = IDX_IN_W'(idx);
        pending_cmds.push_back(c);
    endtask

    // Fill a pool slot with a fresh well-formed number
    task automatic refresh_pool_slot(input int k);
        int n;
        n = $urandom_range(10, MAX_CHARS);
        pool_digits[k] = '0;
        pool_len[k]    = NLEN_W'(n);
        for (int i = 0; i < n; i++) begin
            pool_digits[k][4*i +: 4] = 4'($urandom_range(0, 9));
        end
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Build the random part: mostly pool numbers, some broken words and noise
    task automatic build_random_items();
        int                  k;
        int                  pick;
        int                  pos;
        int                  len;
        logic [DIGITS_W-1:0] d;
        for (int i = 0; i < POOL_SIZE; i++) begin
            refresh_pool_slot(i);
        end
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if ($urandom_range(0, 49) == 0) begin
                refresh_pool_slot($urandom_range(0, POOL_SIZE - 1));
            end
            k    = $urandom_range(0, POOL_SIZE - 1);
            len  = int'(pool_len[k]);
            d    = pool_digits[k] | (rand_word() & ~char_mask(pool_len[k]));
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_cmd(OP_ADD, d, len, $urandom_range(0, 63));
            end else if (pick < 45) begin
                push_cmd(OP_REMOVE, d, len, $urandom_range(0, 63));
            end else if (pick < 67) begin
                push_cmd(OP_CHECK, d, len, $urandom_range(0, 63));
            end else if (pick < 80) begin
                push_cmd(OP_READ, rand_word(), $urandom_range(0, 31),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 17));
            end else if (pick < 87) begin
                if ($urandom_range(0, 2) == 0) begin
                    push_cmd(OP_APPEND, rand_word(), $urandom_range(0, 31),
                             $urandom_range(0, 63));
                end else begin
                    push_cmd(OP_APPEND, d, len, $urandom_range(0, 63));
                end
            end else if (pick == 87 && $urandom_range(0, 2) == 0) begin
                push_cmd(OP_CLEAR, rand_word(), $urandom_range(0, 31), $urandom_range(0, 63));
            end else if (pick < 95) begin
                // Break a pool number: one non-digit or a length off by one
                if ($urandom_range(0, 1) == 0) begin
                    pos = $urandom_range(0, len - 1);
                    d[4*pos +: 4] = 4'($urandom_range(10, 15));
                end else begin
                    len = ($urandom_range(0, 1) == 0) ? len - 1 : len + 1;
                end
                case ($urandom_range(0, 2))
                    0:       push_cmd(OP_ADD, d, len, $urandom_range(0, 63));
                    1:       push_cmd(OP_REMOVE, d, len, $urandom_range(0, 63));
                    default: push_cmd(OP_CHECK, d, len, $urandom_range(0, 63));
                endcase
            end else begin
                push_cmd(OP_W'($urandom_range(0, 7)), rand_word(), $urandom_range(0, 31),
                         $urandom_range(0, 63));
            end
        end
    endtask

    // Record each accepted command word and predict its result
    always @(posedge i_clk) begin
        cmd_word_t taken;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            taken.op     = cmd_ch.operation;
            taken.digits = cmd_ch.number_digits;
            taken.len    = cmd_ch.number_length;
            taken.idx    = cmd_ch.entry_index;
            predicted_rsp.push_back(whitelist_predict(taken));
            accepted_cmds++;
            cmd_taken <= 1'b1;
        end else begin
            cmd_taken <= 1'b0;
        end
    end

    // Drive command words at the falling edge; hold a word until it is taken
    always @(negedge i_clk) begin
        cmd_word_t nxt;
        if ($urandom_range(0, 199) == 0) begin
            send_calm = !send_calm;
        end
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                cmd_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                cmd_ch.operation     <= nxt.op;
                cmd_ch.number_digits <= nxt.digits;
                cmd_ch.number_length <= nxt.len;
                cmd_ch.entry_index   <= nxt.idx;
                cmd_ch.valid         <= 1'b1;
                send_gap = (send_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, and once for a long stretch
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            recv_calm = !recv_calm;
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (!pressure_done && accepted_cmds >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            stall_left    = PRESSURE_HOLD;
            rsp_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        rsp_word_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_rsp.size() == 0) begin
                $display("%0t ns: result word with no command waiting, status %0d",
                         $time, rsp_ch.status);
                mismatch_count++;
            end else begin
                want = predicted_rsp.pop_front();
                report_field("status", 64'(want.status), 64'(rsp_ch.status));
                report_field("authorized", 64'(want.authorized), 64'(rsp_ch.authorized));
                report_field("entry_digits", want.entry_digits, rsp_ch.entry_digits);
                report_field("entry_length", 64'(want.entry_length), 64'(rsp_ch.entry_length));
                report_field("entry_count", 64'(want.entry_count), 64'(rsp_ch.entry_count));
                report_field("persist_request", 64'(want.persist_request),
                             64'(rsp_ch.persist_request));
            end
        end
    end

    // Count cycles without any handshake
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;

        // Directed words: empty table, field extremes, every operation
        push_cmd(OP_READ,    64'h0000_0000_0000_0000, 0, 0);
        push_cmd(OP_CHECK,   64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        push_cmd(OP_ADD,     64'h0000_0098_7654_3210, 10, 0);
        push_cmd(OP_ADD,     64'hABCD_EF98_7654_3210, 10, 63);
        push_cmd(OP_ADD,     64'h0000_0008_7654_3210, 9, 0);
        push_cmd(OP_ADD,     64'hFFFF_FF00_0000_0000, 10, 0);
        push_cmd(OP_ADD,     64'hF999_9999_9999_9999, 15, 0);
        push_cmd(OP_ADD,     64'h1111_1111_1111_1111, 16, 0);
        push_cmd(OP_ADD,     64'h0000_5555_5A55_5555, 12, 0);
        push_cmd(OP_CHECK,   64'h0999_9999_9999_9999, 15, 0);
        push_cmd(OP_CHECK,   64'hFFFF_FFFF_FFFF_FFFF, 16, 0);
        push_cmd(OP_CHECK,   64'h0000_0000_0000_0000, 31, 0);
        push_cmd(OP_CHECK,   64'h0999_9999_9999_9999, 14, 0);
        push_cmd(OP_READ,    64'h0000_0000_0000_0000, 0, 2);
        push_cmd(OP_REMOVE,  64'h0000_0012_3412_3412, 10, 0);
        push_cmd(OP_REMOVE,  64'h1111_1111_1111_1111, 16, 0);
        push_cmd(OP_REMOVE,  64'h0000_0098_7654_3210, 10, 0);
        push_cmd(OP_READ,    64'h0000_0000_0000_0000, 0, 0);
        push_cmd(OP_APPEND,  64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        push_cmd(OP_APPEND,  64'hFEDC_BA98_7654_3210, 31, 0);
        push_cmd(OP_APPEND,  64'hFFFF_FFFF_FFFF_FFAB, 2, 0);
        push_cmd(OP_READ,    64'h0000_0000_0000_0000, 0, 2);
        push_cmd(OP_CHECK,   64'hFEDC_BA98_7654_3210, 15, 0);
        push_cmd(OP_SPARE_A, 64'h0000_0098_7654_3210, 10, 0);
        push_cmd(OP_SPARE_B, 64'h0000_0098_7654_3210, 10, 0);
        push_cmd(OP_CLEAR,   64'h0000_0000_0000_0000, 0, 0);
        build_random_items();

        // Hold reset, release at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words sent and every result back
        while (pending_cmds.size() != 0 || cmd_ch.valid || predicted_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
